@@ rtl/bmv_pkg.sv @@
// Shared types, constants and fixed-point helpers for the blocked
// matrix-vector multiply-add unit. Used by every module in rtl/.
package bmv_pkg;

  localparam int LANES       = 8;
  localparam int MAX_BLOCKS  = 64;
  localparam int IN_FIELDS   = 8;
  localparam int ELEM_W      = 32;
  localparam int BLK_W       = 6;
  localparam int ADDR_W      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int FRAC        = 16;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int TP_W        = PROD_W - FRAC;
  localparam int PAIRS       = (LANES + 1) / 2;
  localparam int PAIR_W      = TP_W + 1;
  localparam int SUM_W       = TP_W + $clog2(LANES);
  localparam int ACC_W       = 64;
  localparam int CFG_IDX_W   = 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [ELEM_W-1:0] SCALE_RESET = ELEM_W'(65536);

  typedef logic signed [ELEM_W-1:0] elem_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_SLICE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA = 1'b0,
    REG_BETA  = 1'b1
  } reg_idx_t;

  typedef struct packed {
    op_t                     op;
    logic [BLK_W-1:0]        blk;
    logic                    in_range;
    logic [LANES-1:0][ELEM_W-1:0] elems;
    logic [ELEM_W-1:0]       self_value;
    logic                    last;
  } item_t;

  // Scales a Q32.32 product down to Q32.16, rounding toward zero.
  function automatic logic signed [TP_W-1:0] trunc_frac(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] biased;
    begin
      biased = p + (p[PROD_W-1] ? PROD_W'((1 << FRAC) - 1) : '0);
      return biased[PROD_W-1:FRAC];
    end
  endfunction

  function automatic logic [ADDR_W-1:0] blk_addr(input logic [BLK_W-1:0] b);
    logic [BLK_W+ADDR_W-1:0] wide;
    begin
      wide = {{ADDR_W{1'b0}}, b};
      return wide[ADDR_W-1:0];
    end
  endfunction

  function automatic logic blk_in_range(input logic [BLK_W-1:0] b);
    logic [BLK_W+ADDR_W-1:0] wide;
    begin
      wide = {{ADDR_W{1'b0}}, b};
      return wide < (BLK_W + ADDR_W)'(MAX_BLOCKS);
    end
  endfunction

endpackage

@@ rtl/bmv_front.sv @@
// Front end: classifies incoming words and holds them in a short queue.
// Depends on bmv_pkg.
module bmv_front import bmv_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic                         cmd,
  input  logic [BLK_W-1:0]             block_index,
  input  logic [IN_FIELDS-1:0][ELEM_W-1:0] elems_in,
  input  logic [ELEM_W-1:0]            self_value,
  input  logic                         last_of_row,
  output item_t                        item,
  output logic                         item_valid,
  input  logic                         item_pop
);

  item_t                         item_in;
  logic [LANES-1:0][ELEM_W-1:0]  lane_elems;
  item_t                         q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]             wr_ptr;
  logic [QPTR_W-1:0]             rd_ptr;
  logic [QCNT_W-1:0]             count;
  logic                          do_push;
  logic                          do_pop;

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    if (l < IN_FIELDS) begin : g_used
      assign lane_elems[l] = elems_in[l];
    end else begin : g_zero
      assign lane_elems[l] = '0;
    end
  end

  always_comb begin
    item_in.op         = cmd ? OP_SLICE : OP_LOAD;
    item_in.blk        = block_index;
    item_in.in_range   = blk_in_range(block_index);
    item_in.elems      = lane_elems;
    item_in.self_value = self_value;
    item_in.last       = cmd & last_of_row;
  end

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign item_valid = (count != '0);
  assign item       = q[rd_ptr];
  assign do_push    = push & ~full;
  assign do_pop     = item_pop & item_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/bmv_back.sv @@
// Back end: vector store, lane multipliers, adder tree, row accumulator
// and the alpha/beta scaling sequence. Depends on bmv_pkg.
module bmv_back import bmv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  item_t             item,
  input  logic              item_valid,
  output logic              item_pop,
  input  logic [ELEM_W-1:0] alpha,
  input  logic [ELEM_W-1:0] beta,
  input  logic              res_full,
  output logic              res_push,
  output logic [ELEM_W-1:0] res_data
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_PAIR  = 9'b000000100,
    S_SUM   = 9'b000001000,
    S_ACC   = 9'b000010000,
    S_MAG   = 9'b000100000,
    S_SCALE = 9'b001000000,
    S_COMB  = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_t;

  localparam logic [PROD_W-1:0] SCALE_CLAMP = PROD_W'(1) << (PROD_W - 2);

  state_t state, state_next;

  logic [LANES-1:0][ELEM_W-1:0] vmem [MAX_BLOCKS];
  logic [LANES-1:0][ELEM_W-1:0] rdata;
  logic [LANES-1:0][ELEM_W-1:0] cur_elems;
  logic                         cur_in_range;
  logic                         cur_last;
  logic [ELEM_W-1:0]            cur_self;
  logic                         mem_we;
  logic                         mem_re;

  logic signed [PROD_W-1:0]     prod [LANES];
  logic signed [TP_W-1:0]       tp [2*PAIRS];
  logic signed [PAIR_W-1:0]     pair [PAIRS];
  logic signed [SUM_W-1:0]      sum;
  logic signed [SUM_W-1:0]      sum_next;
  logic signed [ACC_W-1:0]      acc;
  logic signed [ACC_W:0]        acc_wide;
  logic signed [ACC_W-1:0]      acc_sat;

  logic                         neg;
  logic [ACC_W-1:0]             mag_m;
  logic [ELEM_W-1:0]            mag_a;
  logic signed [PROD_W-1:0]     bprod;
  logic [PROD_W-1:0]            lo;
  logic [PROD_W-1:0]            hi;
  logic signed [TP_W-1:0]       btr;
  logic [PROD_W-1:0]            r_mag;
  logic signed [PROD_W-1:0]     scaled;
  logic signed [PROD_W-1:0]     total;

  assign item_pop = (state == S_IDLE) & item_valid;
  assign mem_we   = item_pop & (item.op == OP_LOAD) & item.in_range;
  assign mem_re   = item_pop & (item.op == OP_SLICE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      vmem[blk_addr(item.blk)] <= item.elems;
    end
    if (mem_re) begin
      rdata <= vmem[blk_addr(item.blk)];
    end
  end

  for (genvar l = 0; l < 2 * PAIRS; l++) begin : g_trunc
    if (l < LANES) begin : g_used
      assign tp[l] = trunc_frac(prod[l]);
    end else begin : g_pad
      assign tp[l] = '0;
    end
  end

  always_comb begin
    sum_next = '0;
    for (int p = 0; p < PAIRS; p++) begin
      sum_next = sum_next + SUM_W'(pair[p]);
    end
  end

  always_comb begin
    acc_wide = {acc[ACC_W-1], acc} + (ACC_W + 1)'(sum);
    if (acc_wide[ACC_W] != acc_wide[ACC_W-1]) begin
      acc_sat = acc_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      acc_sat = acc_wide[ACC_W-1:0];
    end
  end

  always_comb begin
    if (|hi[PROD_W-1:PROD_W-FRAC-2]) begin
      r_mag = SCALE_CLAMP;
    end else begin
      r_mag = {hi[PROD_W-FRAC-1:0], {FRAC{1'b0}}} + {{FRAC{1'b0}}, lo[PROD_W-1:FRAC]};
      if (r_mag > SCALE_CLAMP) begin
        r_mag = SCALE_CLAMP;
      end
    end
  end

  always_comb begin
    total = scaled + PROD_W'(btr);
    if (total[PROD_W-1:ELEM_W-1] == '0 || total[PROD_W-1:ELEM_W-1] == '1) begin
      res_data = total[ELEM_W-1:0];
    end else begin
      res_data = total[PROD_W-1] ? {1'b1, {(ELEM_W-1){1'b0}}} : {1'b0, {(ELEM_W-1){1'b1}}};
    end
  end

  assign res_push = (state == S_EMIT) & ~res_full;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (mem_re) begin
                 state_next = S_MUL;
               end
      S_MUL:   state_next = S_PAIR;
      S_PAIR:  state_next = S_SUM;
      S_SUM:   state_next = S_ACC;
      S_ACC:   state_next = cur_last ? S_MAG : S_IDLE;
      S_MAG:   state_next = S_SCALE;
      S_SCALE: state_next = S_COMB;
      S_COMB:  state_next = S_EMIT;
      S_EMIT:  if (res_push) begin
                 state_next = S_IDLE;
               end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      acc   <= '0;
    end else begin
      state <= state_next;
      if (state == S_ACC) begin
        acc <= acc_sat;
      end else if (state == S_MAG) begin
        acc <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_re) begin
      cur_elems    <= item.elems;
      cur_in_range <= item.in_range;
      cur_last     <= item.last;
      cur_self     <= item.self_value;
    end
    if (state == S_MUL) begin
      for (int l = 0; l < LANES; l++) begin
        prod[l] <= $signed(cur_elems[l]) * (cur_in_range ? $signed(rdata[l]) : $signed(ELEM_W'(0)));
      end
    end
    if (state == S_PAIR) begin
      for (int p = 0; p < PAIRS; p++) begin
        pair[p] <= PAIR_W'(tp[2*p]) + PAIR_W'(tp[2*p+1]);
      end
    end
    if (state == S_SUM) begin
      sum <= sum_next;
    end
    if (state == S_MAG) begin
      neg   <= alpha[ELEM_W-1] ^ acc[ACC_W-1];
      mag_m <= acc[ACC_W-1] ? (ACC_W'(0) - acc) : acc;
      mag_a <= alpha[ELEM_W-1] ? (ELEM_W'(0) - alpha) : alpha;
      bprod <= $signed(beta) * $signed(cur_self);
    end
    if (state == S_SCALE) begin
      lo  <= PROD_W'(mag_m[ELEM_W-1:0]) * PROD_W'(mag_a);
      hi  <= PROD_W'(mag_m[ACC_W-1:ELEM_W]) * PROD_W'(mag_a);
      btr <= trunc_frac(bprod);
    end
    if (state == S_COMB) begin
      scaled <= neg ? (PROD_W'(0) - r_mag) : r_mag;
    end
  end

endmodule

@@ rtl/bmv_res_queue.sv @@
// Result queue: holds finished row results until the consumer pops them.
// Depends on bmv_pkg.
module bmv_res_queue import bmv_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              res_push,
  input  logic [ELEM_W-1:0] res_data,
  output logic              res_full,
  output logic              empty,
  input  logic              pop,
  output logic [ELEM_W-1:0] head
);

  logic [ELEM_W-1:0] q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign res_full = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign head     = q[rd_ptr];
  assign do_push  = res_push & ~res_full;
  assign do_pop   = pop & ~empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= res_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ rtl/blocked_matrix_vector_addmv_unit.sv @@
// Blocked matrix-vector multiply-add, result = alpha*(M.v) + beta*self in Q16.16.
// The sequencer in the back end runs one word at a time and takes no new word until it is
// through with the one before; a last slice waits to emit while the result queue is full.
// A last slice steps through the states MUL, PAIR, SUM, ACC, MAG, SCALE, COMB and EMIT.
// Reset clears both queues, the row accumulator and the sequencer, and sets alpha and
// beta to 1.0; the vector store is not cleared and must be loaded before use.
module blocked_matrix_vector_addmv_unit import bmv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 cmd,
  input  logic [BLK_W-1:0]     block_index,
  input  logic signed [31:0]   elem_0,
  input  logic signed [31:0]   elem_1,
  input  logic signed [31:0]   elem_2,
  input  logic signed [31:0]   elem_3,
  input  logic signed [31:0]   elem_4,
  input  logic signed [31:0]   elem_5,
  input  logic signed [31:0]   elem_6,
  input  logic signed [31:0]   elem_7,
  input  logic signed [31:0]   self_value,
  input  logic                 last_of_row,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [31:0]   row_result,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  logic [IN_FIELDS-1:0][ELEM_W-1:0] raw_elems;
  item_t                            item;
  logic                             item_valid;
  logic                             item_pop;
  logic [ELEM_W-1:0]                alpha;
  logic [ELEM_W-1:0]                beta;
  logic                             res_full;
  logic                             res_push;
  logic [ELEM_W-1:0]                res_data;
  logic [ELEM_W-1:0]                head;

  assign raw_elems  = {elem_7, elem_6, elem_5, elem_4, elem_3, elem_2, elem_1, elem_0};
  assign cfg_ready  = 1'b1;
  assign row_result = $signed(head);

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= SCALE_RESET;
      beta  <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ALPHA: alpha <= cfg_data;
        REG_BETA:  beta  <= cfg_data;
        default:   alpha <= alpha;
      endcase
    end
  end

  bmv_front u_front (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .cmd         (cmd),
    .block_index (block_index),
    .elems_in    (raw_elems),
    .self_value  (self_value),
    .last_of_row (last_of_row),
    .item        (item),
    .item_valid  (item_valid),
    .item_pop    (item_pop)
  );

  bmv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .alpha      (alpha),
    .beta       (beta),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_data   (res_data)
  );

  bmv_res_queue u_res_queue (
    .clk      (clk),
    .rst      (rst),
    .res_push (res_push),
    .res_data (res_data),
    .res_full (res_full),
    .empty    (empty),
    .pop      (pop),
    .head     (head)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("Result pushed into a full result queue.");

  a_pop_only_valid: assert property (@(posedge clk) disable iff (rst)
    item_pop |-> item_valid)
    else $error("Back end took a word from an empty front queue.");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("Queues not empty after reset.");

endmodule
